/* hw/rtl/u64a_pkg.sv */
package u64a_pkg;

	// Widths fixed by the item format
	localparam int VALUE_W         = 64;
	localparam int DEF_VALUE_WIDTH = 64;
	localparam int CHAR_W          = 7;
	localparam int DIGIT_W         = 4;

	// ASCII bases and the double dabble correction
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
	localparam logic [DIGIT_W-1:0] DEC_TEN    = 4'd10;
	localparam logic [DIGIT_W-1:0] DAB_LIMIT  = 4'd5;
	localparam logic [DIGIT_W-1:0] DAB_ADD    = 4'd3;

	// Control from the sequencer to the digit register
	typedef struct packed {
		logic load;    // start a new item
		logic hex;     // with load: place the value as hex digits, else clear
		logic step;    // one double dabble step
		logic bit_in;  // with step: next value bit, MSB first
		logic shift;   // drop the top digit
	} dig_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		if (d < DEC_TEN)
			return ASCII_ZERO + CHAR_W'(d);
		return ASCII_A + CHAR_W'(d - DEC_TEN);
	endfunction

endpackage

/* hw/rtl/u64a_digits.sv */
module u64a_digits #(
	parameter int VALUE_WIDTH = 64,
	parameter int DEC_DIGITS  = 20,
	parameter int HEX_DIGITS  = 16
) (
	input  logic                            clk,
	input  u64a_pkg::dig_ctl_t              ctl,
	input  logic [VALUE_WIDTH-1:0]          value,
	output logic [u64a_pkg::DIGIT_W-1:0]    top_digit
);
	import u64a_pkg::*;

	localparam int DW = DEC_DIGITS * DIGIT_W;
	localparam int HW = HEX_DIGITS * DIGIT_W;

	logic [DW-1:0] dig_q;
	logic [DW-1:0] adj;
	logic [HW-1:0] hex_val;
	logic [DW-1:0] hex_load;

	// Correct every BCD digit that would overflow on the next doubling
	always_comb begin
		adj = dig_q;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (dig_q[i*DIGIT_W +: DIGIT_W] >= DAB_LIMIT)
				adj[i*DIGIT_W +: DIGIT_W] = dig_q[i*DIGIT_W +: DIGIT_W] + DAB_ADD;
		end
	end

	// Align hex digits so the most significant one sits in the top slot
	assign hex_val  = HW'(value);
	assign hex_load = DW'(hex_val) << (DW - HW);

	// Load, dabble or shift out one digit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dig_q <= ctl.hex ? hex_load : '0;
		end else if (ctl.step) begin
			dig_q <= {adj[DW-2:0], ctl.bit_in};
		end else if (ctl.shift) begin
			dig_q <= {dig_q[DW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign top_digit = dig_q[DW-1 -: DIGIT_W];

endmodule

/* hw/rtl/u64_to_ascii_digits.sv */
// Converts one unsigned number per input item into its ASCII digits, one output
// item per digit, most significant first, without leading zeros; zero gives a
// single '0'. s_tuser selects the radix (0 decimal, 1 hex with upper-case A-F),
// and m_tlast marks the final digit. Only the low VALUE_WIDTH bits of s_tdata
// are used. After the accept a decimal item goes through the bit-serial double
// dabble register, one value bit per cycle; a hex item skips that. Then the
// leading zero digit slots are dropped one by one, and the digits are sent to
// the output register, each held back while it is full and m_tready is low. One
// item is in work at a time; the next is taken while the last digit still waits
// in the output register.
module u64_to_ascii_digits #(
	parameter int VALUE_WIDTH = u64a_pkg::DEF_VALUE_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [u64a_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
	input  logic                       s_tuser,   // [0] cmd (0 decimal, 1 hex)
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [6:0] digit_char, [7] zero
	output logic                       m_tlast    // last_digit
);
	import u64a_pkg::*;

	localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int HEX_DIGITS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int REM_W      = $clog2(DEC_DIGITS + 1);
	localparam int CNT_W      = $clog2(VALUE_WIDTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;

	dig_ctl_t               ctl;
	logic [DIGIT_W-1:0]     top_digit;
	logic                   in_acc;
	logic                   slot_free;
	logic                   emit;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign emit      = (state_q == ST_EMIT) && slot_free;

	// Drive the digit register from the sequencer state
	always_comb begin
		ctl.load   = in_acc;
		ctl.hex    = s_tuser;
		ctl.step   = (state_q == ST_CONV);
		ctl.bit_in = val_q[VALUE_WIDTH-1];
		ctl.shift  = emit ||
			((state_q == ST_SKIP) && (top_digit == '0) && (rem_q > REM_W'(1)));
	end

	u64a_digits #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DEC_DIGITS  (DEC_DIGITS),
		.HEX_DIGITS  (HEX_DIGITS)
	) u_digits (
		.clk       (clk),
		.ctl       (ctl),
		.value     (s_tdata[VALUE_WIDTH-1:0]),
		.top_digit (top_digit)
	);

	// Sequence conversion, leading zero drop and digit output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= CNT_W'(VALUE_WIDTH - 1);
						if (s_tuser) begin
							rem_q   <= REM_W'(HEX_DIGITS);
							state_q <= ST_SKIP;
						end else begin
							rem_q   <= REM_W'(DEC_DIGITS);
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (ctl.shift)
						rem_q <= rem_q - REM_W'(1);
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the value bits, MSB first into the dabble register
	always_ff @(posedge clk) begin
		if (in_acc)
			val_q <= s_tdata[VALUE_WIDTH-1:0];
		else if (state_q == ST_CONV)
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
	end

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= digit_to_ascii(top_digit);
			out_last_q <= (rem_q == REM_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

/* tb/u64_to_ascii_digits_tb.sv */
module u64_to_ascii_digits_tb;
	import u64a_pkg::*;

	// One digit as it should leave the block
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	// Digit predictor and store of digits still owed by the block
	class digit_scoreboard;
		digit_t owed[$];
		int     n_items;
		int     n_hex;
		int     n_digits;
		int     n_errors;

		function new();
			n_items  = 0;
			n_hex    = 0;
			n_digits = 0;
			n_errors = 0;
		endfunction

		function logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
			if (d < DEC_TEN)
				return ASCII_ZERO + CHAR_W'(d);
			return ASCII_A + CHAR_W'(d - DEC_TEN);
		endfunction

		// Split one accepted number into digits, most significant first
		function void note_number(input logic hex, input logic [VALUE_W-1:0] val);
			logic [DIGIT_W-1:0] rev[20];
			logic [VALUE_W-1:0] n;
			int                 cnt;
			digit_t             dg;
			n   = val;
			cnt = 0;
			do begin
				if (hex) begin
					rev[cnt] = n[3:0];
					n        = n >> 4;
				end else begin
					rev[cnt] = DIGIT_W'(n % 64'd10);
					n        = n / 64'd10;
				end
				cnt++;
			end while (n != 0 && cnt < 20);
			for (int k = 0; k < cnt; k++) begin
				dg.ch   = glyph_of(rev[cnt - 1 - k]);
				dg.last = (k == cnt - 1);
				owed.push_back(dg);
			end
			n_items++;
			if (hex)
				n_hex++;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		task report_mismatch(input string what);
			n_errors++;
			$display("ERROR @%0t: %s", $time, what);
		endtask

		// Compare one accepted digit against the oldest owed one
		task check_digit(input logic [7:0] data, input logic last);
			digit_t dg;
			n_digits++;
			if (owed.size() == 0) begin
				report_mismatch($sformatf("unexpected digit 0x%02h last=%0b", data, last));
				return;
			end
			dg = owed.pop_front();
			if (data !== {1'b0, dg.ch})
				report_mismatch($sformatf("digit 0x%02h, want 0x%02h", data, {1'b0, dg.ch}));
			if (last !== dg.last)
				report_mismatch($sformatf("last %0b, want %0b on digit 0x%02h",
					last, dg.last, data));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata;   // [63:0] value
	logic               s_tuser;   // [0] cmd (0 decimal, 1 hex)
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // [6:0] digit_char, [7] zero
	logic               m_tlast;   // last_digit

	digit_scoreboard sb;
	int              burst_left;

	u64_to_ascii_digits DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#4000000;
		$display("u64_to_ascii_digits_tb failed");
		$finish;
	end

	// Receiver: switch between stall patterns every so often
	initial begin
		int mode;
		int span;
		int phase;
		m_tready = 1'b0;
		mode     = 0;
		span     = 0;
		phase    = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			phase++;
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (phase % 8 == 0);
				default: m_tready <= (phase % 5 < 3);
			endcase
		end
	end

	// Check every digit taken from the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_digit(m_tdata, m_tlast);
	end

	function automatic logic [VALUE_W-1:0] pow10(input int k);
		logic [VALUE_W-1:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++)
			p = p * 64'd10;
		return p;
	endfunction

	// Offer one number, wait for it to be taken, then pace the burst
	task automatic send_number(input logic hex, input logic [VALUE_W-1:0] val);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= hex;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_number(hex, val);
		burst_left--;
		if (burst_left <= 0) begin
			gap        = $urandom_range(0, 12);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= {$urandom, $urandom};
				s_tuser  <= 1'($urandom_range(0, 1));
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// Hold off the sender until every owed digit is out
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic               hex;
		logic [VALUE_W-1:0] raw;
		logic [VALUE_W-1:0] val;
		int                 sel;
		int                 width;
		int                 k;

		sb         = new();
		burst_left = 1;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes, every digit glyph and the zero case in both radices
		send_number(1'b0, 64'd0);
		send_number(1'b1, 64'd0);
		send_number(1'b0, 64'd1);
		send_number(1'b0, 64'd9);
		send_number(1'b0, 64'd10);
		send_number(1'b1, 64'hA);
		send_number(1'b1, 64'hF);
		send_number(1'b1, 64'h10);
		send_number(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_number(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_number(1'b0, pow10(19) - 64'd1);
		send_number(1'b0, pow10(19));
		send_number(1'b0, 64'h8000_0000_0000_0000);
		send_number(1'b1, 64'h8000_0000_0000_0000);
		send_number(1'b1, 64'h0123_4567_89AB_CDEF);
		send_number(1'b1, 64'hFEDC_BA98_7654_3210);
		send_number(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
		send_number(1'b0, 64'h5555_5555_5555_5555);
		send_number(1'b0, 64'd12345678901234567890);
		send_number(1'b0, 64'd9876543210);
		wait_idle();

		// Random numbers: full width, random width, and near digit boundaries
		for (int i = 0; i < 340; i++) begin
			hex = 1'($urandom_range(0, 1));
			sel = $urandom_range(0, 9);
			raw = {$urandom, $urandom};
			if (sel < 4) begin
				val = raw;
			end else if (sel < 8) begin
				width = $urandom_range(0, 64);
				val   = (width == 64) ? raw : raw & ((64'd1 << width) - 64'd1);
			end else if (sel == 8) begin
				k   = $urandom_range(0, 19);
				val = pow10(k) + 64'($urandom_range(0, 4)) - 64'd2;
			end else begin
				k   = $urandom_range(0, 15);
				val = (64'd1 << (4 * k)) + 64'($urandom_range(0, 4)) - 64'd2;
			end
			send_number(hex, val);
			if (i == 170)
				wait_idle();
		end

		// Drain, then give the block time to show any stray digit
		wait_idle();
		repeat (150) @(negedge clk);

		$display("Converted %0d numbers (%0d decimal, %0d hex), %0d digits checked.",
			sb.n_items, sb.n_items - sb.n_hex, sb.n_hex, sb.n_digits);
		$display("Mismatches found: %0d", sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("u64_to_ascii_digits_tb passed");
		else
			$display("u64_to_ascii_digits_tb failed");
		$finish;
	end

endmodule
